// File: rtl/msbl_pkg.sv
// types, codes and constants shared by the bounded list buffer
// no dependencies
package msbl_pkg;

	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_BAD_SIZE  = 4'd1,
		ST_BAD_SLOT  = 4'd2,
		ST_EXISTS    = 4'd3,
		ST_NO_MEMORY = 4'd4,
		ST_NO_LIST   = 4'd5,
		ST_FULL      = 4'd6,
		ST_EMPTY     = 4'd7,
		ST_NOT_FOUND = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_META,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		op_t                mode;
		logic [3:0]         slot;
		logic [7:0]         length;
		logic signed [31:0] value;
	} req_beat_t;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count_after;
	} rsp_beat_t;

endpackage

// File: rtl/msbl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module msbl_ram #(
	parameter int W = 32,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/multi_slot_bounded_list.sv
// bounded list buffer top level, depends on msbl_pkg and msbl_ram
// create, insert and pop run S_META then S_RESP, where the result is loaded into the output register;
// delete runs S_SCAN over the held entries after S_META and, on a match, S_SHIFT before S_RESP
// one request at a time: the next is taken the cycle after its result is loaded, so
// no new request is taken while one is in progress or its result waits on a stalled output
// reset clears the sequencer, output valid flag and exists flags; the rams need no clearing pass
module multi_slot_bounded_list #(
	parameter int SLOTS        = 10,
	parameter int MAX_CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  msbl_pkg::req_beat_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output msbl_pkg::rsp_beat_t  rsp
);

	localparam int DEPTH = SLOTS * MAX_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(MAX_CAPACITY + 1);
	localparam int MW    = 2 * CW;

	msbl_pkg::seq_state_t state_q, state_d;

	msbl_pkg::req_beat_t req_q;
	logic [SW-1:0]       s_q, s_d;
	logic                slot_ok_q, slot_ok_d;
	logic [AW-1:0]       base_q;
	logic [SLOTS-1:0]    exists_q;
	logic                exists_set;
	logic [CW-1:0]       n_q, n_d;
	logic [CW-1:0]       cap_q, cap_d;
	logic [CW-1:0]       idx_q, idx_d;
	msbl_pkg::status_t   res_status_q, res_status_d;
	logic [CW-1:0]       res_cnt_q, res_cnt_d;
	logic                rsp_valid_q;
	msbl_pkg::rsp_beat_t rsp_q;
	logic                rsp_load;

	logic          req_take;
	logic          meta_we;
	logic [MW-1:0] meta_wdata;
	logic [MW-1:0] meta_rdata;
	logic          ent_we, ent_re;
	logic [AW-1:0] ent_waddr, ent_raddr;
	logic [31:0]   ent_wdata, ent_rdata;

	logic          ex;
	logic [CW-1:0] cur_cnt, cur_cap;
	logic [CW:0]   nxt1, nxt2;

	assign req_stall = (state_q != msbl_pkg::S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign slot_ok_d = (req.slot != 4'd0) && ({3'b000, req.slot} <= 7'(SLOTS));
	assign s_d       = slot_ok_d ? SW'(req.slot - 4'd1) : '0;

	assign ex      = exists_q[s_q];
	assign cur_cnt = ex ? meta_rdata[MW-1:CW] : '0;
	assign cur_cap = meta_rdata[CW-1:0];
	assign nxt1    = {1'b0, idx_q} + (CW+1)'(1);
	assign nxt2    = {1'b0, idx_q} + (CW+1)'(2);

	msbl_ram #(.W(MW), .D(SLOTS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (s_q),
		.wdata (meta_wdata),
		.re    (req_take),
		.raddr (s_d),
		.rdata (meta_rdata)
	);

	msbl_ram #(.W(32), .D(DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_comb begin
		state_d      = state_q;
		n_d          = n_q;
		cap_d        = cap_q;
		idx_d        = idx_q;
		res_status_d = res_status_q;
		res_cnt_d    = res_cnt_q;
		exists_set   = 1'b0;
		meta_we      = 1'b0;
		meta_wdata   = '0;
		ent_we       = 1'b0;
		ent_waddr    = base_q;
		ent_wdata    = ent_rdata;
		ent_re       = 1'b0;
		ent_raddr    = base_q;
		rsp_load     = 1'b0;
		unique case (state_q)
			msbl_pkg::S_IDLE: begin
				if (req_take) begin
					state_d = msbl_pkg::S_META;
				end
			end
			msbl_pkg::S_META: begin
				state_d      = msbl_pkg::S_RESP;
				res_status_d = msbl_pkg::ST_OK;
				res_cnt_d    = slot_ok_q ? cur_cnt : '0;
				n_d          = cur_cnt;
				cap_d        = cur_cap;
				if (req_q.mode == msbl_pkg::OP_CREATE) begin
					priority if (req_q.length == 8'd0) begin
						res_status_d = msbl_pkg::ST_BAD_SIZE;
					end else if (!slot_ok_q) begin
						res_status_d = msbl_pkg::ST_BAD_SLOT;
					end else if (ex) begin
						res_status_d = msbl_pkg::ST_EXISTS;
					end else if (req_q.length > 8'(MAX_CAPACITY)) begin
						res_status_d = msbl_pkg::ST_NO_MEMORY;
					end else begin
						exists_set = 1'b1;
						meta_we    = 1'b1;
						meta_wdata = {{CW{1'b0}}, CW'(req_q.length)};
						res_cnt_d  = '0;
					end
				end else begin
					priority if (!slot_ok_q) begin
						res_status_d = msbl_pkg::ST_BAD_SLOT;
					end else if (!ex) begin
						res_status_d = msbl_pkg::ST_NO_LIST;
					end else if (req_q.mode == msbl_pkg::OP_INSERT) begin
						if (cur_cnt >= cur_cap || cur_cnt >= CW'(MAX_CAPACITY)) begin
							res_status_d = msbl_pkg::ST_FULL;
						end else begin
							ent_we     = 1'b1;
							ent_waddr  = base_q + AW'(cur_cnt);
							ent_wdata  = req_q.value;
							meta_we    = 1'b1;
							meta_wdata = {cur_cnt + CW'(1), cur_cap};
							res_cnt_d  = cur_cnt + CW'(1);
						end
					end else if (cur_cnt == '0) begin
						res_status_d = msbl_pkg::ST_EMPTY;
					end else if (req_q.mode == msbl_pkg::OP_POP) begin
						meta_we    = 1'b1;
						meta_wdata = {cur_cnt - CW'(1), cur_cap};
						res_cnt_d  = cur_cnt - CW'(1);
					end else begin
						// delete: start the scan at the first entry
						ent_re    = 1'b1;
						ent_raddr = base_q;
						idx_d     = '0;
						state_d   = msbl_pkg::S_SCAN;
					end
				end
			end
			msbl_pkg::S_SCAN: begin
				// read-ahead of the next entry, it feeds the shift on a match
				if (nxt1 < {1'b0, n_q}) begin
					ent_re    = 1'b1;
					ent_raddr = base_q + AW'(nxt1);
				end
				if (ent_rdata == req_q.value) begin
					state_d = msbl_pkg::S_SHIFT;
				end else if (nxt1 >= {1'b0, n_q}) begin
					res_status_d = msbl_pkg::ST_NOT_FOUND;
					res_cnt_d    = n_q;
					state_d      = msbl_pkg::S_RESP;
				end else begin
					idx_d = CW'(nxt1);
				end
			end
			msbl_pkg::S_SHIFT: begin
				if (nxt1 < {1'b0, n_q}) begin
					// rdata holds entry idx+1, move it down to idx
					ent_we    = 1'b1;
					ent_waddr = base_q + AW'(idx_q);
					ent_wdata = ent_rdata;
					if (nxt2 < {1'b0, n_q}) begin
						ent_re    = 1'b1;
						ent_raddr = base_q + AW'(nxt2);
					end
					idx_d = CW'(nxt1);
				end else begin
					meta_we      = 1'b1;
					meta_wdata   = {n_q - CW'(1), cap_q};
					res_status_d = msbl_pkg::ST_OK;
					res_cnt_d    = n_q - CW'(1);
					state_d      = msbl_pkg::S_RESP;
				end
			end
			msbl_pkg::S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = msbl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = msbl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msbl_pkg::S_IDLE;
			exists_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exists_set) begin
				exists_q[s_q] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q     <= req;
			s_q       <= s_d;
			slot_ok_q <= slot_ok_d;
			base_q    <= AW'(s_d) * AW'(MAX_CAPACITY);
		end
		n_q          <= n_d;
		cap_q        <= cap_d;
		idx_q        <= idx_d;
		res_status_q <= res_status_d;
		res_cnt_q    <= res_cnt_d;
		if (rsp_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.count_after <= msbl_pkg::COUNT_W'(res_cnt_q);
		end
	end

	// a slot never holds more than its capacity
	a_meta_bound: assert property (@(posedge clk) disable iff (!arst_n)
		meta_we |-> (meta_wdata[MW-1:CW] <= meta_wdata[CW-1:0]))
		else $error("slot count written above capacity");

	// the shift only runs inside the held entries
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msbl_pkg::S_SHIFT) |-> (idx_q < n_q))
		else $error("shift index beyond slot count");

	// a scan is only started on a non-empty slot
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msbl_pkg::S_SCAN) |-> (n_q != '0))
		else $error("scan on empty slot");

	// a finished result reaches the output register and frees the sequencer
	a_resp_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == msbl_pkg::S_RESP) && (!rsp_valid_q || !rsp_stall))
		|=> (rsp_valid_q && (state_q == msbl_pkg::S_IDLE)))
		else $error("result not handed to output register");

endmodule

// File: tb/tb_multi_slot_bounded_list.sv
// self-checking testbench for multi_slot_bounded_list: create, insert, pop and delete
// beats are checked against a local predictor of the slot lists
// depends on msbl_pkg and the rtl of the block
module tb_multi_slot_bounded_list;

	localparam int SLOTS    = 10;
	localparam int MAX_CAP  = 64;
	localparam int N_RANDOM = 1725;
	localparam int TAIL     = 2 * MAX_CAP + 20;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	msbl_pkg::req_beat_t req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	msbl_pkg::rsp_beat_t rsp;

	// predicted contents of each slot
	logic signed [31:0] list_words [SLOTS][MAX_CAP];
	int                 list_len   [SLOTS];
	int                 list_cap   [SLOTS];
	bit                 list_made  [SLOTS];

	msbl_pkg::rsp_beat_t expected_rsp[$];
	int        err_count   = 0;
	bit        tx_steady   = 1'b0;
	bit        rx_steady   = 1'b0;
	int        rx_hold_left = 0;

	multi_slot_bounded_list #(
		.SLOTS(SLOTS),
		.MAX_CAPACITY(MAX_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	initial begin
		#(20 * 1_500_000);
		$display("tb_multi_slot_bounded_list: errors");
		$finish;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	// small pool so that duplicates show up and deletes hit
	function automatic logic signed [31:0] pick_word();
		unique case ($urandom_range(0, 6))
			0: return -32'sd1;
			1: return 32'sd0;
			2: return 32'sd1;
			3: return 32'h8000_0000;
			4: return 32'h7fff_ffff;
			5: return 32'($urandom_range(2, 5));
			default: return $urandom();
		endcase
	endfunction

	function automatic msbl_pkg::req_beat_t make_beat(input msbl_pkg::op_t m, input int slot,
			input int len, input logic signed [31:0] v);
		msbl_pkg::req_beat_t b;
		b.mode   = m;
		b.slot   = 4'(slot);
		b.length = 8'(len);
		b.value  = v;
		return b;
	endfunction

	function automatic msbl_pkg::rsp_beat_t run_list_op(input msbl_pkg::req_beat_t b);
		msbl_pkg::rsp_beat_t o;
		bit        ok_slot;
		int        s;
		int        hit;
		ok_slot  = int'(b.slot) >= 1 && int'(b.slot) <= SLOTS;
		s        = ok_slot ? int'(b.slot) - 1 : 0;
		o.status = msbl_pkg::ST_OK;
		if (b.mode == msbl_pkg::OP_CREATE) begin
			if (b.length == 0)
				o.status = msbl_pkg::ST_BAD_SIZE;
			else if (!ok_slot)
				o.status = msbl_pkg::ST_BAD_SLOT;
			else if (list_made[s])
				o.status = msbl_pkg::ST_EXISTS;
			else if (int'(b.length) > MAX_CAP)
				o.status = msbl_pkg::ST_NO_MEMORY;
			else begin
				list_made[s] = 1'b1;
				list_cap[s]  = int'(b.length);
				list_len[s]  = 0;
			end
		end else if (!ok_slot) begin
			o.status = msbl_pkg::ST_BAD_SLOT;
		end else if (!list_made[s]) begin
			o.status = msbl_pkg::ST_NO_LIST;
		end else if (b.mode == msbl_pkg::OP_INSERT) begin
			if (list_len[s] >= list_cap[s])
				o.status = msbl_pkg::ST_FULL;
			else begin
				list_words[s][list_len[s]] = b.value;
				list_len[s]++;
			end
		end else if (list_len[s] == 0) begin
			o.status = msbl_pkg::ST_EMPTY;
		end else if (b.mode == msbl_pkg::OP_POP) begin
			list_len[s]--;
		end else begin
			hit = -1;
			for (int i = 0; i < list_len[s]; i++)
				if (hit < 0 && list_words[s][i] == b.value)
					hit = i;
			if (hit < 0)
				o.status = msbl_pkg::ST_NOT_FOUND;
			else begin
				for (int i = hit; i + 1 < list_len[s]; i++)
					list_words[s][i] = list_words[s][i + 1];
				list_len[s]--;
			end
		end
		o.count_after = ok_slot ? 7'(list_len[s]) : '0;
		return o;
	endfunction

	// mostly well-formed ops on created slots, some creates, a little noise
	function automatic msbl_pkg::req_beat_t random_beat();
		int made_idx[$];
		int r;
		int s;
		int m;
		r = $urandom_range(0, 99);
		if (r < 4)
			return make_beat(msbl_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
				$urandom_range(0, 255), $urandom());
		if (r < 10)
			return make_beat(msbl_pkg::OP_CREATE, $urandom_range(1, SLOTS),
				$urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(1, MAX_CAP),
				$urandom());
		for (int i = 0; i < SLOTS; i++)
			if (list_made[i])
				made_idx.push_back(i);
		s = made_idx.size() > 0 ? made_idx[$urandom_range(0, made_idx.size() - 1)]
			: $urandom_range(0, SLOTS - 1);
		m = $urandom_range(0, 99);
		if (m < 45)
			return make_beat(msbl_pkg::OP_INSERT, s + 1, $urandom_range(0, 255),
				$urandom_range(0, 1) ? pick_word() : $urandom());
		if (m < 60)
			return make_beat(msbl_pkg::OP_POP, s + 1, $urandom_range(0, 255), $urandom());
		if (list_len[s] > 0 && $urandom_range(0, 9) < 7)
			return make_beat(msbl_pkg::OP_DELETE, s + 1, $urandom_range(0, 255),
				list_words[s][$urandom_range(0, list_len[s] - 1)]);
		return make_beat(msbl_pkg::OP_DELETE, s + 1, $urandom_range(0, 255), pick_word());
	endfunction

	// valid stays high from one beat to the next unless a gap is taken or the bench waits for results
	task automatic send_beat(input msbl_pkg::req_beat_t b);
		int gap;
		gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(run_list_op(b));
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rsp.size() != 0);
	endtask

	initial begin : rsp_checker
		msbl_pkg::rsp_beat_t want;
		int        stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected result beat status %0d count %0d",
						$time, rsp.status, rsp.count_after);
					err_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, rsp.status);
						err_count++;
					end
					if (rsp.count_after !== want.count_after) begin
						$display("%0t: count_after expected %0d got %0d",
							$time, want.count_after, rsp.count_after);
						err_count++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
				rsp_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	task automatic test_error_codes();
		send_beat(make_beat(msbl_pkg::OP_POP, 3, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 3, 0, 5));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 3, 0, 5));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 0, 5, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 15, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 11, 10, 0));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 0, 255, -1));
		send_beat(make_beat(msbl_pkg::OP_POP, 12, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 15, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 1, 65, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 1, 255, 0));
	endtask

	task automatic test_small_slot();
		send_beat(make_beat(msbl_pkg::OP_CREATE, 1, 1, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 1, 1, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 1, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 1, 0, 32'h8000_0000));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 1, 0, 32'h7fff_ffff));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 1, 0, 32'h7fff_ffff));
		// match sits in the last held entry
		send_beat(make_beat(msbl_pkg::OP_DELETE, 1, 0, 32'h8000_0000));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 1, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_POP, 1, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_CREATE, 10, 64, 0));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 10, 0, -1));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 10, 0, 32'h7fff_ffff));
		send_beat(make_beat(msbl_pkg::OP_POP, 10, 0, 0));
	endtask

	task automatic test_fill_and_drain();
		while (list_len[9] < list_cap[9])
			send_beat(make_beat(msbl_pkg::OP_INSERT, 10, 0,
				$urandom_range(0, 1) ? pick_word() : $urandom()));
		send_beat(make_beat(msbl_pkg::OP_INSERT, 10, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 10, 0, list_words[9][list_len[9] - 1]));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 10, 0, list_words[9][0]));
		repeat (10)
			send_beat(make_beat(msbl_pkg::OP_DELETE, 10, 0,
				list_words[9][$urandom_range(0, list_len[9] - 1)]));
		while (list_len[9] > 0)
			send_beat(make_beat(msbl_pkg::OP_POP, 10, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_POP, 10, 0, 0));
		send_beat(make_beat(msbl_pkg::OP_DELETE, 10, 0, 0));
	endtask

	task automatic test_sender_pause();
		repeat (6)
			send_beat(random_beat());
		wait_for_results();
		repeat (6)
			send_beat(random_beat());
	endtask

	task automatic test_receiver_hold_off();
		rx_hold_left = 300;
		repeat (10)
			send_beat(random_beat());
		wait_for_results();
	endtask

	task automatic test_random_ops();
		for (int i = 0; i < N_RANDOM; i++) begin
			tx_steady = (i % 300) >= 260;
			rx_steady = tx_steady;
			send_beat(random_beat());
			if (i % 250 == 249)
				wait_for_results();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			list_len[i]  = 0;
			list_cap[i]  = 0;
			list_made[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_error_codes();
		test_small_slot();
		test_fill_and_drain();
		test_sender_pause();
		test_receiver_hold_off();
		test_random_ops();
		wait_for_results();
		repeat (TAIL) @(posedge clk);
		if (err_count == 0)
			$display("tb_multi_slot_bounded_list: clean");
		else
			$display("tb_multi_slot_bounded_list: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/msbl_pkg.sv
rtl/msbl_ram.sv
rtl/multi_slot_bounded_list.sv
tb/tb_multi_slot_bounded_list.sv
